// ----- hdl/tpaff_pkg.sv -----
// Package for the three point affine transform block.
// Holds the default coordinate width and the register map constants.
// No dependencies.
package tpaff_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // Register map.
  localparam int CFG_NUM = 6;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_C = 3'd5;

  // Coefficient setup sequencer: ten products, two per coefficient.
  localparam int SEQ_W = 4;
  localparam logic [SEQ_W-1:0] SEQ_LAST = 4'd9;
  localparam int COEF_NUM = 5;
  localparam int COEF_DET = 0;
  localparam int COEF_KXX = 1;
  localparam int COEF_KXY = 2;
  localparam int COEF_KYX = 3;
  localparam int COEF_KYY = 4;

endpackage

// ----- hdl/three_point_affine_transform_top.sv -----
// Three point affine transform, top level.
// Depends on tpaff_pkg for the register map and default width.
//
// Usage: six 64-bit control point registers are written on the cfg channel
// (index 0..5: source A, B, C, target A, B, C; x in bits 63..32, y in bits
// 31..0). After every write a sequencer forms the determinant and the four
// cross-product coefficients with one shared multiplier; cfg_ready and
// in_ready are low during that time.
// Points enter on the in channel, one transaction per cycle while in_ready is
// high, and leave on the out channel in order. The restoring divider retires
// one quotient bit per stage. Throughput is one point per cycle when neither
// a setup nor an output stall holds the pipeline.
// A stall on the out channel freezes the whole pipeline; nothing is lost and
// in_ready drops until the output register is taken. Reset zeroes the control
// point and coefficient registers, so the source points are collinear and
// points pass unchanged with degenerate set until configured.
module three_point_affine_transform_top #(
  parameter int COORD_WIDTH = tpaff_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_point_x,
  input  logic signed [31:0]                in_point_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_mapped_x,
  output logic signed [31:0]                out_mapped_y,
  output logic                              out_degenerate,
  output logic                              out_clipped,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpaff_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                       cfg_data
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;          // coordinate difference
  localparam int QW = 2 * DW;         // product of two differences
  localparam int KW = QW + 1;         // determinant and coefficients
  localparam int LW = W + 2;          // low slice of a coefficient
  localparam int HW = KW - LW;        // high slice of a coefficient
  localparam int PW = KW + DW;        // coefficient times difference
  localparam int NW = PW + 1;         // numerator
  localparam int SW = NW + 2;         // sum before saturation

  typedef struct packed {
    logic          neg_x;
    logic          neg_y;
    logic [W-1:0]  px;
    logic [W-1:0]  py;
    logic [NW-1:0] qx;
    logic [NW-1:0] qy;
    logic [KW-1:0] rx;
    logic [KW-1:0] ry;
  } dstg_t;

  function automatic logic signed [DW-1:0] sx(input logic [W-1:0] a);
    return {a[W-1], a};
  endfunction

  function automatic logic [NW+KW-1:0] dstep(input logic [KW-1:0] rem,
                                             input logic [NW-1:0] q,
                                             input logic [KW-1:0] d);
    logic [KW:0] rs;
    logic [KW:0] df;
    rs = {rem, q[NW-1]};
    df = rs - {1'b0, d};
    if (!df[KW]) begin
      return {df[KW-1:0], q[NW-2:0], 1'b1};
    end
    return {rs[KW-1:0], q[NW-2:0], 1'b0};
  endfunction

  // ---------------- configuration and coefficient setup ----------------
  logic [63:0] cfg_r [tpaff_pkg::CFG_NUM];
  logic run_r, pv_r;
  logic [tpaff_pkg::SEQ_W-1:0] step_r, pstep_r;
  logic signed [QW-1:0] prod_r, first_r;
  logic signed [KW-1:0] coef_r [tpaff_pkg::COEF_NUM];
  logic [KW-1:0] dabs_r;
  logic dneg_r, det_zero_r;
  logic busy, cfg_acc;
  logic signed [DW-1:0] sxb, syb, sxc, syc, txb, tyb, txc, tyc, opa, opb;
  logic [W-1:0] xa_s, ya_s, xa_t, ya_t;

  assign busy    = run_r | pv_r;
  assign cfg_ready = ~busy;
  assign cfg_acc = cfg_valid & cfg_ready;

  assign xa_s = cfg_r[tpaff_pkg::REG_SOURCE_A][32+W-1:32];
  assign ya_s = cfg_r[tpaff_pkg::REG_SOURCE_A][W-1:0];
  assign xa_t = cfg_r[tpaff_pkg::REG_TARGET_A][32+W-1:32];
  assign ya_t = cfg_r[tpaff_pkg::REG_TARGET_A][W-1:0];
  assign sxb = sx(cfg_r[tpaff_pkg::REG_SOURCE_B][32+W-1:32]) - sx(xa_s);
  assign syb = sx(cfg_r[tpaff_pkg::REG_SOURCE_B][W-1:0]) - sx(ya_s);
  assign sxc = sx(cfg_r[tpaff_pkg::REG_SOURCE_C][32+W-1:32]) - sx(xa_s);
  assign syc = sx(cfg_r[tpaff_pkg::REG_SOURCE_C][W-1:0]) - sx(ya_s);
  assign txb = sx(cfg_r[tpaff_pkg::REG_TARGET_B][32+W-1:32]) - sx(xa_t);
  assign tyb = sx(cfg_r[tpaff_pkg::REG_TARGET_B][W-1:0]) - sx(ya_t);
  assign txc = sx(cfg_r[tpaff_pkg::REG_TARGET_C][32+W-1:32]) - sx(xa_t);
  assign tyc = sx(cfg_r[tpaff_pkg::REG_TARGET_C][W-1:0]) - sx(ya_t);

  // Each coefficient is the first product of its pair minus the second.
  always_comb begin
    case (step_r)
      4'd0:    begin opa = sxb; opb = syc; end
      4'd1:    begin opa = sxc; opb = syb; end
      4'd2:    begin opa = txb; opb = syc; end
      4'd3:    begin opa = txc; opb = syb; end
      4'd4:    begin opa = txc; opb = sxb; end
      4'd5:    begin opa = txb; opb = sxc; end
      4'd6:    begin opa = tyb; opb = syc; end
      4'd7:    begin opa = tyc; opb = syb; end
      4'd8:    begin opa = tyc; opb = sxb; end
      4'd9:    begin opa = tyb; opb = sxc; end
      default: begin opa = '0;  opb = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tpaff_pkg::CFG_NUM; i++) cfg_r[i] <= '0;
      for (int i = 0; i < tpaff_pkg::COEF_NUM; i++) coef_r[i] <= '0;
      run_r      <= 1'b0;
      pv_r       <= 1'b0;
      step_r     <= '0;
      pstep_r    <= '0;
      det_zero_r <= 1'b1;
    end else begin
      if (cfg_acc && cfg_index < tpaff_pkg::CFG_IDX_W'(tpaff_pkg::CFG_NUM)) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      if (cfg_acc) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r == tpaff_pkg::SEQ_LAST) run_r <= 1'b0;
        else step_r <= step_r + 1'b1;
      end
      pv_r    <= run_r;
      pstep_r <= step_r;
      if (pv_r && pstep_r[0]) begin
        coef_r[pstep_r[tpaff_pkg::SEQ_W-1:1]] <= KW'(first_r) - KW'(prod_r);
        if (pstep_r[tpaff_pkg::SEQ_W-1:1] == 3'(tpaff_pkg::COEF_DET)) begin
          det_zero_r <= (KW'(first_r) - KW'(prod_r)) == '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    if (pv_r && !pstep_r[0]) first_r <= prod_r;
    dneg_r <= coef_r[tpaff_pkg::COEF_DET][KW-1];
    dabs_r <= coef_r[tpaff_pkg::COEF_DET][KW-1] ?
              KW'(-coef_r[tpaff_pkg::COEF_DET]) : coef_r[tpaff_pkg::COEF_DET];
  end

  // ---------------- point pipeline ----------------
  logic en, in_acc;
  logic out_valid_r;
  assign en       = out_ready | ~out_valid_r;
  assign in_ready = en & ~busy;
  assign in_acc   = in_valid & in_ready;

  // Stage 1: offsets from source point A.
  logic v1_r;
  logic signed [DW-1:0] u1_r, w1_r;
  logic [W-1:0] px1_r, py1_r;
  // Stage 2: partial products.
  logic v2_r;
  logic signed [DW+LW:0]   pl2_r [4];
  logic signed [DW+HW-1:0] ph2_r [4];
  logic [W-1:0] px2_r, py2_r;
  // Stage 3: full products.
  logic v3_r;
  logic signed [PW-1:0] p3_r [4];
  logic [W-1:0] px3_r, py3_r;
  // Stage 4: numerators.
  logic v4_r;
  logic signed [NW-1:0] nx4_r, ny4_r;
  logic [W-1:0] px4_r, py4_r;
  // Divider stages; index 0 holds the magnitudes.
  logic [NW:0] dv_r;
  dstg_t ds_r [NW+1];
  // Post stages.
  logic va_r, vb_r;
  logic signed [NW:0] qxa_r, qya_r;
  logic signed [SW-1:0] sxb_r, syb_r;
  logic [W-1:0] pxa_r, pya_r, pxb_r, pyb_r;
  logic signed [31:0] mx_r, my_r;
  logic deg_r, clip_r;

  logic signed [KW-1:0] kmul [4];
  logic signed [DW-1:0] dmul [4];
  assign kmul[0] = coef_r[tpaff_pkg::COEF_KXX];
  assign kmul[1] = coef_r[tpaff_pkg::COEF_KXY];
  assign kmul[2] = coef_r[tpaff_pkg::COEF_KYX];
  assign kmul[3] = coef_r[tpaff_pkg::COEF_KYY];
  assign dmul[0] = u1_r;
  assign dmul[1] = w1_r;
  assign dmul[2] = u1_r;
  assign dmul[3] = w1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      dv_r <= '0; va_r <= 1'b0; vb_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r <= {dv_r[NW-1:0], v4_r};
      va_r <= dv_r[NW];
      vb_r <= va_r;
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r  <= sx(in_point_x[W-1:0]) - sx(xa_s);
      w1_r  <= sx(in_point_y[W-1:0]) - sx(ya_s);
      px1_r <= in_point_x[W-1:0];
      py1_r <= in_point_y[W-1:0];

      for (int i = 0; i < 4; i++) begin
        pl2_r[i] <= dmul[i] * $signed({1'b0, kmul[i][LW-1:0]});
        ph2_r[i] <= dmul[i] * $signed(kmul[i][KW-1:LW]);
        p3_r[i]  <= (PW'(ph2_r[i]) <<< LW) + PW'(pl2_r[i]);
      end
      px2_r <= px1_r; py2_r <= py1_r;
      px3_r <= px2_r; py3_r <= py2_r;

      nx4_r <= NW'(p3_r[0]) + NW'(p3_r[1]);
      ny4_r <= NW'(p3_r[2]) + NW'(p3_r[3]);
      px4_r <= px3_r; py4_r <= py3_r;

      ds_r[0].neg_x <= nx4_r[NW-1] ^ dneg_r;
      ds_r[0].neg_y <= ny4_r[NW-1] ^ dneg_r;
      ds_r[0].px    <= px4_r;
      ds_r[0].py    <= py4_r;
      ds_r[0].qx    <= nx4_r[NW-1] ? NW'(-nx4_r) : nx4_r;
      ds_r[0].qy    <= ny4_r[NW-1] ? NW'(-ny4_r) : ny4_r;
      ds_r[0].rx    <= '0;
      ds_r[0].ry    <= '0;

      // Quotient sign applied, then target base added.
      qxa_r <= ds_r[NW].neg_x ? -$signed({1'b0, ds_r[NW].qx}) : $signed({1'b0, ds_r[NW].qx});
      qya_r <= ds_r[NW].neg_y ? -$signed({1'b0, ds_r[NW].qy}) : $signed({1'b0, ds_r[NW].qy});
      pxa_r <= ds_r[NW].px; pya_r <= ds_r[NW].py;
      sxb_r <= SW'(qxa_r) + SW'($signed(xa_t));
      syb_r <= SW'(qya_r) + SW'($signed(ya_t));
      pxb_r <= pxa_r; pyb_r <= pya_r;
    end
  end

  // One quotient bit per stage for both coordinates.
  for (genvar g = 0; g < NW; g++) begin : g_div
    logic [NW+KW-1:0] nxt_x, nxt_y;
    assign nxt_x = dstep(ds_r[g].rx, ds_r[g].qx, dabs_r);
    assign nxt_y = dstep(ds_r[g].ry, ds_r[g].qy, dabs_r);
    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[g+1].neg_x <= ds_r[g].neg_x;
        ds_r[g+1].neg_y <= ds_r[g].neg_y;
        ds_r[g+1].px    <= ds_r[g].px;
        ds_r[g+1].py    <= ds_r[g].py;
        ds_r[g+1].rx    <= nxt_x[NW+KW-1:NW];
        ds_r[g+1].qx    <= nxt_x[NW-1:0];
        ds_r[g+1].ry    <= nxt_y[NW+KW-1:NW];
        ds_r[g+1].qy    <= nxt_y[NW-1:0];
      end
    end
  end

  // Saturation to the coordinate range.
  logic signed [SW-1:0] hi_c, lo_c;
  logic hx, lx, hy, ly;
  logic signed [W-1:0] satx, saty, hiw, low;
  assign hi_c = SW'({1'b0, {(W-1){1'b1}}});
  assign lo_c = ~hi_c;
  assign hiw  = {1'b0, {(W-1){1'b1}}};
  assign low  = ~hiw;
  assign hx = sxb_r > hi_c;
  assign lx = sxb_r < lo_c;
  assign hy = syb_r > hi_c;
  assign ly = syb_r < lo_c;
  assign satx = hx ? hiw : (lx ? low : sxb_r[W-1:0]);
  assign saty = hy ? hiw : (ly ? low : syb_r[W-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (det_zero_r) begin
        mx_r   <= 32'($signed(pxb_r));
        my_r   <= 32'($signed(pyb_r));
        deg_r  <= 1'b1;
        clip_r <= 1'b0;
      end else begin
        mx_r   <= 32'(satx);
        my_r   <= 32'(saty);
        deg_r  <= 1'b0;
        clip_r <= hx | lx | hy | ly;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mapped_x   = mx_r;
  assign out_mapped_y   = my_r;
  assign out_degenerate = deg_r;
  assign out_clipped    = clip_r;

  // ---------------- assertions ----------------
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready && !cfg_ready)
    else $error("transaction accepted during coefficient setup");

  a_cfg_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> run_r && step_r == '0)
    else $error("setup did not start after a configuration write");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> v1_r)
    else $error("accepted transaction missing from first stage");

  a_deg_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_clipped)
    else $error("degenerate result flagged as clipped");

endmodule
